[hw/rtl/dqs_pkg.sv]
// Shared types, command and status codes for the deque with linear search.
// No dependencies.
package dqs_pkg;

    localparam int CmdW    = 3;
    localparam int DataW   = 32;
    localparam int StatusW = 2;
    localparam int PosW    = 5;

    localparam logic [CmdW-1:0] CMD_PUSH_HEAD = 3'd0;
    localparam logic [CmdW-1:0] CMD_PUSH_TAIL = 3'd1;
    localparam logic [CmdW-1:0] CMD_POP_HEAD  = 3'd2;
    localparam logic [CmdW-1:0] CMD_POP_TAIL  = 3'd3;
    localparam logic [CmdW-1:0] CMD_SEARCH    = 3'd4;

    localparam logic [StatusW-1:0] ST_OK        = 2'd0;
    localparam logic [StatusW-1:0] ST_EMPTY     = 2'd1;
    localparam logic [StatusW-1:0] ST_FULL      = 2'd2;
    localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH_HEAD,
        OP_PUSH_TAIL,
        OP_POP_HEAD,
        OP_POP_TAIL,
        OP_SEARCH,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [DataW-1:0]  value;
    } t_work;

    typedef struct packed {
        logic [StatusW-1:0]       status;
        logic signed [DataW-1:0]  removed_value;
        logic [PosW-1:0]          found_position;
    } t_result;

    function automatic t_op decode_cmd(input logic [CmdW-1:0] cmd);
        t_op op;
        unique case (cmd)
            CMD_PUSH_HEAD: op = OP_PUSH_HEAD;
            CMD_PUSH_TAIL: op = OP_PUSH_TAIL;
            CMD_POP_HEAD:  op = OP_POP_HEAD;
            CMD_POP_TAIL:  op = OP_POP_TAIL;
            CMD_SEARCH:    op = OP_SEARCH;
            default:       op = OP_NOP;
        endcase
        return op;
    endfunction

    function automatic t_result make_result(input logic [StatusW-1:0] status,
                                            input logic signed [DataW-1:0] removed,
                                            input logic [PosW-1:0] pos);
        t_result res;
        res.status         = status;
        res.removed_value  = removed;
        res.found_position = pos;
        return res;
    endfunction

endpackage

[hw/rtl/dqs_if.sv]
// Valid/ready channel interfaces for commands and results.
// Depends on dqs_pkg.
interface dqs_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [dqs_pkg::CmdW-1:0]             cmd;
    logic signed [dqs_pkg::DataW-1:0]     item_value;

    modport source (output valid, output cmd, output item_value, input ready);
    modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface dqs_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [dqs_pkg::StatusW-1:0]          status;
    logic signed [dqs_pkg::DataW-1:0]     removed_value;
    logic [dqs_pkg::PosW-1:0]             found_position;

    modport source (output valid, output status, output removed_value,
                    output found_position, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input found_position, output ready);
endinterface

[hw/rtl/deque_with_linear_search_top.sv]
// Top level of the deque with linear search: command front end, queue and
// execution back end. Depends on dqs_pkg, dqs_if, dqs_front, dqs_back.
//
//  channel   dir  transfer                fields
//  i_cmd     in   i_cmd.valid & ready     cmd, item_value
//  o_res     out  o_res.valid & ready     status, removed_value, found_position
//
// Inserts, unknown codes and empty/full cases finish in the back end's idle
// state. Removals take one registered RAM read (S_POP). A search walks the
// entries until the matched position or the entry count is reached, paced by
// the single RAM read port walking one entry a cycle. A command is registered
// in the front queue. Reset is synchronous; the store needs no clearing pass.
// A stalled result holds the back end; the two-entry queue accepts until full.
module deque_with_linear_search_top #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dqs_cmd_if.sink     i_cmd,
    dqs_res_if.source   o_res
);

    dqs_pkg::t_work work;
    logic           work_valid;
    logic           work_take;

    dqs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_work       (work),
        .o_work_valid (work_valid),
        .i_work_take  (work_take)
    );

    dqs_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (work),
        .i_work_valid (work_valid),
        .o_work_take  (work_take),
        .o_res        (o_res)
    );

endmodule

[hw/rtl/dqs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/dqs_front.sv]
// Command front end: accepts command transfers, decodes them and holds them
// in a two-entry queue for the back end. Depends on dqs_pkg, dqs_if.
module dqs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dqs_cmd_if.sink         i_cmd,
    output dqs_pkg::t_work  o_work,
    output logic            o_work_valid,
    input  logic            i_work_take
);

    dqs_pkg::t_work r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign i_cmd.ready  = (r_cnt != 2'd2);
    assign push         = i_cmd.valid && i_cmd.ready;
    assign pop          = i_work_take && (r_cnt != 2'd0);
    assign o_work_valid = (r_cnt != 2'd0);
    assign o_work       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr].op    <= dqs_pkg::decode_cmd(i_cmd.cmd);
            r_q[r_wr_ptr].value <= i_cmd.item_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

[hw/rtl/dqs_back.sv]
// Execution back end: ring store with head index and count, removal reads
// and the linear search walk, plus the result register.
// Depends on dqs_pkg, dqs_if, dqs_ram.
module dqs_back #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dqs_pkg::t_work  i_work,
    input  logic            i_work_valid,
    output logic            o_work_take,
    dqs_res_if.source       o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > dqs_pkg::PosW) ? CW : dqs_pkg::PosW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SRCH
    } t_state;

    t_state                           r_state;
    logic [AW-1:0]                    r_head;
    logic [CW-1:0]                    r_count;
    logic [AW-1:0]                    r_pos;
    logic                             r_pop_head;
    logic signed [dqs_pkg::DataW-1:0] r_value;
    logic                             r_out_valid;
    dqs_pkg::t_result                 r_out;

    logic                             take;
    logic                             out_free;
    logic                             out_load;
    logic                             full;
    logic                             empty;
    logic                             we;
    logic [AW-1:0]                    waddr;
    logic [AW-1:0]                    raddr;
    logic [AW-1:0]                    head_dec;
    logic [dqs_pkg::DataW-1:0]        rdata;
    logic [CW-1:0]                    pos_next;
    logic [PW-1:0]                    pos_out;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign out_free = !r_out_valid || o_res.ready;
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign pos_next = CW'(r_pos) + CW'(1);
    assign pos_out  = PW'(r_pos) + PW'(1);

    always_comb begin
        take     = 1'b0;
        we       = 1'b0;
        out_load = 1'b0;
        waddr    = r_head;
        raddr    = r_head;
        unique case (r_state)
            S_IDLE: begin
                take = i_work_valid && out_free;
                unique case (i_work.op)
                    dqs_pkg::OP_PUSH_HEAD: begin
                        waddr    = head_dec;
                        we       = take && !full;
                        out_load = take;
                    end
                    dqs_pkg::OP_PUSH_TAIL: begin
                        waddr    = wrap_add(r_head, r_count);
                        we       = take && !full;
                        out_load = take;
                    end
                    dqs_pkg::OP_POP_TAIL: begin
                        raddr    = wrap_add(r_head, r_count - CW'(1));
                        out_load = take && empty;
                    end
                    dqs_pkg::OP_POP_HEAD, dqs_pkg::OP_SEARCH: begin
                        raddr    = r_head;
                        out_load = take && empty;
                    end
                    default: begin
                        raddr    = r_head;
                        out_load = take;
                    end
                endcase
            end
            S_POP: begin
                raddr    = r_head;
                out_load = 1'b1;
            end
            S_SRCH: begin
                raddr    = wrap_add(r_head, pos_next);
                out_load = ($signed(rdata) == r_value) || (pos_next == r_count);
            end
            default: begin
                raddr = r_head;
            end
        endcase
    end

    assign o_work_take = take;

    dqs_ram #(
        .WIDTH (dqs_pkg::DataW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_work.value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_value    <= i_work.value;
                        r_pos      <= '0;
                        r_pop_head <= (i_work.op == dqs_pkg::OP_POP_HEAD);
                        unique case (i_work.op)
                            dqs_pkg::OP_PUSH_HEAD, dqs_pkg::OP_PUSH_TAIL: begin
                                if (full) begin
                                    r_out <= dqs_pkg::make_result(dqs_pkg::ST_FULL,
                                                                  '0, '0);
                                end else begin
                                    r_out   <= dqs_pkg::make_result(dqs_pkg::ST_OK,
                                                                    '0, '0);
                                    r_count <= r_count + CW'(1);
                                    if (i_work.op == dqs_pkg::OP_PUSH_HEAD) begin
                                        r_head <= head_dec;
                                    end
                                end
                            end
                            dqs_pkg::OP_POP_HEAD, dqs_pkg::OP_POP_TAIL: begin
                                if (empty) begin
                                    r_out <= dqs_pkg::make_result(dqs_pkg::ST_EMPTY,
                                                                  '0, '0);
                                end else begin
                                    r_state <= S_POP;
                                end
                            end
                            dqs_pkg::OP_SEARCH: begin
                                if (empty) begin
                                    r_out <= dqs_pkg::make_result(dqs_pkg::ST_EMPTY,
                                                                  '0, '0);
                                end else begin
                                    r_state <= S_SRCH;
                                end
                            end
                            default: begin
                                r_out <= dqs_pkg::make_result(dqs_pkg::ST_OK, '0, '0);
                            end
                        endcase
                    end
                end
                S_POP: begin
                    r_out   <= dqs_pkg::make_result(dqs_pkg::ST_OK, rdata, '0);
                    r_count <= r_count - CW'(1);
                    if (r_pop_head) begin
                        r_head <= wrap_add(r_head, CW'(1));
                    end
                    r_state <= S_IDLE;
                end
                S_SRCH: begin
                    if ($signed(rdata) == r_value) begin
                        r_out   <= dqs_pkg::make_result(dqs_pkg::ST_OK, '0,
                                                        pos_out[dqs_pkg::PosW-1:0]);
                        r_state <= S_IDLE;
                    end else if (pos_next == r_count) begin
                        r_out   <= dqs_pkg::make_result(dqs_pkg::ST_NOT_FOUND, '0, '0);
                        r_state <= S_IDLE;
                    end else begin
                        r_pos <= r_pos + AW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out.status;
    assign o_res.removed_value  = r_out.removed_value;
    assign o_res.found_position = r_out.found_position;

endmodule
